>>> sv/gats_pkg.sv
// Shared types and constants of the graph adjacency tie store.
// No dependencies; each other file but gats_ram refers to it by scoped names.
`timescale 1ns / 1ps
package gats_pkg;

  localparam int unsigned NODES  = 64;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned DEG_W  = 7;
  localparam int unsigned ROW_W  = 64;

  localparam logic [ROW_W-1:0] NODE_MASK =
      (NODES >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << NODES) - ROW_W'(1));
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);
  localparam logic [NODE_W:0]   NODES_V   = (NODE_W + 1)'(NODES);

  typedef enum logic [3:0] {
    REQ_ADD    = 4'd0,
    REQ_REMOVE = 4'd1,
    REQ_TIE    = 4'd2,
    REQ_OUT    = 4'd3,
    REQ_IN     = 4'd4,
    REQ_RECIP  = 4'd5,
    REQ_BACK   = 4'd6,
    REQ_UP     = 4'd7,
    REQ_DOWN   = 4'd8,
    REQ_FWD    = 4'd9,
    REQ_DIST2  = 4'd10
  } req_e;

  typedef enum logic {
    CFG_DIRECTED  = 1'b0,
    CFG_REFLEXIVE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_U_RD,
    ST_U_WR,
    ST_M_RD,
    ST_M_WR,
    ST_A_RD,
    ST_B_RD,
    ST_B_CAP,
    ST_WALK,
    ST_W_END,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_UPD,
    RD_MIR,
    RD_A,
    RD_B,
    RD_K
  } rd_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    out_valid;
    rd_sel_e rd_sel;
    logic    upd_wr;
    logic    mir_wr;
    logic    cap_a;
    logic    cap_b;
    logic    walk_step;
    logic    walk_end;
  } ctrl_t;

  typedef struct packed {
    logic acc_upd;
    logic mirror;
    logic walk;
    logic walk_last;
  } stat_t;

endpackage

>>> sv/gats_ram.sv
// Single write, single read port RAM with registered read and per-entry valid bits.
// Entries never written read as zero. No package dependency.
`timescale 1ns / 1ps
module gats_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

>>> sv/gats_ctrl.sv
// Request sequencer of the graph adjacency tie store.
// Depends on gats_pkg for state, control and status types.
`timescale 1ns / 1ps
module gats_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_ready_i,
  input  gats_pkg::stat_t stat_i,
  output gats_pkg::ctrl_t ctrl_o
);

  gats_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gats_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gats_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.acc_upd ? gats_pkg::ST_U_RD : gats_pkg::ST_A_RD;
        end
      end
      gats_pkg::ST_U_RD:  state_d = gats_pkg::ST_U_WR;
      gats_pkg::ST_U_WR:  state_d = stat_i.mirror ? gats_pkg::ST_M_RD : gats_pkg::ST_A_RD;
      gats_pkg::ST_M_RD:  state_d = gats_pkg::ST_M_WR;
      gats_pkg::ST_M_WR:  state_d = gats_pkg::ST_A_RD;
      gats_pkg::ST_A_RD:  state_d = gats_pkg::ST_B_RD;
      gats_pkg::ST_B_RD:  state_d = gats_pkg::ST_B_CAP;
      gats_pkg::ST_B_CAP: state_d = stat_i.walk ? gats_pkg::ST_WALK : gats_pkg::ST_OUT;
      gats_pkg::ST_WALK: begin
        if (stat_i.walk_last) begin
          state_d = gats_pkg::ST_W_END;
        end
      end
      gats_pkg::ST_W_END: state_d = gats_pkg::ST_OUT;
      gats_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = gats_pkg::ST_IDLE;
        end
      end
      default:            state_d = gats_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.rd_sel = gats_pkg::RD_NONE;
    case (state_q)
      gats_pkg::ST_IDLE:  ctrl_o.in_ready  = 1'b1;
      gats_pkg::ST_U_RD:  ctrl_o.rd_sel    = gats_pkg::RD_UPD;
      gats_pkg::ST_U_WR:  ctrl_o.upd_wr    = 1'b1;
      gats_pkg::ST_M_RD:  ctrl_o.rd_sel    = gats_pkg::RD_MIR;
      gats_pkg::ST_M_WR:  ctrl_o.mir_wr    = 1'b1;
      gats_pkg::ST_A_RD:  ctrl_o.rd_sel    = gats_pkg::RD_A;
      gats_pkg::ST_B_RD: begin
        ctrl_o.rd_sel = gats_pkg::RD_B;
        ctrl_o.cap_a  = 1'b1;
      end
      gats_pkg::ST_B_CAP: ctrl_o.cap_b     = 1'b1;
      gats_pkg::ST_WALK: begin
        ctrl_o.rd_sel    = gats_pkg::RD_K;
        ctrl_o.walk_step = 1'b1;
      end
      gats_pkg::ST_W_END: ctrl_o.walk_end  = 1'b1;
      gats_pkg::ST_OUT:   ctrl_o.out_valid = 1'b1;
      default:            ctrl_o.in_ready  = 1'b0;
    endcase
  end

endmodule

>>> sv/graph_adjacency_tie_store_core.sv
// Top level of the graph adjacency tie store: datapath, row and degree RAMs.
// Depends on gats_pkg, gats_ram and gats_ctrl.
`timescale 1ns / 1ps
// Usage:
//  - Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//    (CFG_DIRECTED, CFG_REFLEXIVE). Write only while the block is idle.
//  - Input channel: in_valid_i / in_ready_o carry one request (req_type_i,
//    node_a_i, node_b_i) per transfer. in_ready_o is high only when no
//    request is in work and no result is held.
//  - Output channel: out_valid_o / out_ready_i carry one result per request.
//    The result is held in registers until the transfer; a stalled receiver
//    simply holds the block in its output state.
//  - States from input transfer to out_valid_o: queries (tie, set and
//    intersection queries, unused codes) pass A_RD, B_RD, B_CAP, OUT;
//    add / remove first U_RD, U_WR and, when the mirror tie is updated,
//    M_RD, M_WR; distance two adds WALK (one out row read per cycle) and
//    W_END before OUT. Each item occupies the block until its result
//    transfers. The single read port of each row RAM sets the path: every
//    row touched needs its own read; the distance-two walk visits every row.
//  - Reset: all ties and degrees read as zero (per-entry valid bits are
//    cleared at once), directed = 1, reflexive = 0. No clearing pass.
module graph_adjacency_tie_store_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  req_type_i,
  input  logic [5:0]  node_a_i,
  input  logic [5:0]  node_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic        tie_present_o,
  output logic [6:0]  out_degree_o,
  output logic [6:0]  in_degree_o,
  output logic [63:0] node_set_o
);

  localparam int unsigned NW = gats_pkg::NODE_W;
  localparam int unsigned DW = gats_pkg::DEG_W;
  localparam int unsigned RW = gats_pkg::ROW_W;

  gats_pkg::ctrl_t ctrl;
  gats_pkg::stat_t stat;

  // configuration registers
  logic directed_q, reflexive_q;

  // latched request
  logic [3:0]    req_q;
  logic [NW-1:0] a_q, b_q;

  // result registers
  logic          ok_q, tie_q;
  logic [DW-1:0] odeg_q, ideg_q;
  logic [RW-1:0] set_q;
  logic [RW-1:0] rowa_out_q, rowa_in_q;

  // distance-two walk
  logic [RW-1:0] acc_q, acc_nxt;
  logic [NW-1:0] k_q, kp_q;
  logic          kv_q;

  // RAM ports
  logic [NW-1:0] out_ra, in_ra, od_ra, id_ra;
  logic [RW-1:0] out_rd, in_rd, out_wd, in_wd;
  logic [DW-1:0] od_rd, id_rd, od_wd, id_wd;
  logic          wr_en;

  // shared tie update unit
  logic [NW-1:0] s_node, t_node;
  logic          value, now, in_range, self_tie, refused, change;
  logic [RW-1:0] set_b;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  gats_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = ctrl.out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q  <= 1'b1;
      reflexive_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gats_pkg::CFG_DIRECTED:  directed_q  <= cfg_data_i;
        gats_pkg::CFG_REFLEXIVE: reflexive_q <= cfg_data_i;
        default:                 directed_q  <= directed_q;
      endcase
    end
  end

  // Source and target of the direction under update: forward, then mirror.
  assign s_node   = ctrl.mir_wr ? b_q : a_q;
  assign t_node   = ctrl.mir_wr ? a_q : b_q;
  assign value    = (req_q == gats_pkg::REQ_ADD);
  assign now      = out_rd[t_node];
  assign in_range = ({1'b0, a_q} < gats_pkg::NODES_V) && ({1'b0, b_q} < gats_pkg::NODES_V);
  assign self_tie = (a_q == b_q) && !reflexive_q;
  assign refused  = in_range && (now != value) && self_tie;
  assign change   = in_range && (now != value) && !self_tie;
  assign wr_en    = (ctrl.upd_wr || ctrl.mir_wr) && change;

  always_comb begin
    out_wd = out_rd;
    in_wd  = in_rd;
    out_wd[t_node] = value;
    in_wd[s_node]  = value;
    od_wd = value ? (od_rd + DW'(1)) : (od_rd - DW'(1));
    id_wd = value ? (id_rd + DW'(1)) : (id_rd - DW'(1));
  end

  assign stat.acc_upd   = (req_type_i == gats_pkg::REQ_ADD) ||
                          (req_type_i == gats_pkg::REQ_REMOVE);
  assign stat.mirror    = change && !directed_q;
  assign stat.walk      = (req_q == gats_pkg::REQ_DIST2);
  assign stat.walk_last = (k_q == gats_pkg::LAST_NODE);

  // Read addresses: in updates, out and od follow the source, in and id the target.
  always_comb begin
    out_ra = a_q;
    in_ra  = a_q;
    od_ra  = a_q;
    id_ra  = a_q;
    case (ctrl.rd_sel)
      gats_pkg::RD_UPD: begin
        in_ra = b_q;
        id_ra = b_q;
      end
      gats_pkg::RD_MIR: begin
        out_ra = b_q;
        od_ra  = b_q;
      end
      gats_pkg::RD_B: begin
        out_ra = b_q;
        in_ra  = b_q;
        od_ra  = b_q;
        id_ra  = b_q;
      end
      gats_pkg::RD_K:   out_ra = k_q;
      default:          out_ra = a_q;
    endcase
  end

  gats_ram #(.WIDTH(RW), .AW(NW)) u_out_rows (
    .clk_i(clk_i), .rst_ni(rst_ni), .we_i(wr_en), .waddr_i(s_node),
    .wdata_i(out_wd), .raddr_i(out_ra), .rdata_o(out_rd)
  );
  gats_ram #(.WIDTH(RW), .AW(NW)) u_in_rows (
    .clk_i(clk_i), .rst_ni(rst_ni), .we_i(wr_en), .waddr_i(t_node),
    .wdata_i(in_wd), .raddr_i(in_ra), .rdata_o(in_rd)
  );
  gats_ram #(.WIDTH(DW), .AW(NW)) u_out_deg (
    .clk_i(clk_i), .rst_ni(rst_ni), .we_i(wr_en), .waddr_i(s_node),
    .wdata_i(od_wd), .raddr_i(od_ra), .rdata_o(od_rd)
  );
  gats_ram #(.WIDTH(DW), .AW(NW)) u_in_deg (
    .clk_i(clk_i), .rst_ni(rst_ni), .we_i(wr_en), .waddr_i(t_node),
    .wdata_i(id_wd), .raddr_i(id_ra), .rdata_o(id_rd)
  );

  // Set answer once both rows of node_b are on the read port.
  always_comb begin
    case (req_q)
      gats_pkg::REQ_OUT:   set_b = rowa_out_q;
      gats_pkg::REQ_IN:    set_b = rowa_in_q;
      gats_pkg::REQ_RECIP: set_b = rowa_in_q & rowa_out_q;
      gats_pkg::REQ_BACK:  set_b = rowa_in_q & out_rd;
      gats_pkg::REQ_UP:    set_b = rowa_out_q & out_rd;
      gats_pkg::REQ_DOWN:  set_b = rowa_in_q & in_rd;
      gats_pkg::REQ_FWD:   set_b = rowa_out_q & in_rd;
      default:             set_b = '0;
    endcase
  end

  // OR in the out row of the previous walk node when it is an out-neighbor.
  assign acc_nxt = (kv_q && rowa_out_q[kp_q]) ? (acc_q | out_rd) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q <= 1'b0;
      k_q  <= '0;
    end else if (ctrl.cap_b) begin
      kv_q <= 1'b0;
      k_q  <= '0;
    end else if (ctrl.walk_step) begin
      kv_q <= 1'b1;
      k_q  <= k_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= req_type_i;
      a_q   <= node_a_i;
      b_q   <= node_b_i;
      ok_q  <= 1'b1;
    end
    if (ctrl.upd_wr && refused) begin
      ok_q <= 1'b0;
    end
    if (ctrl.cap_a) begin
      rowa_out_q <= out_rd;
      rowa_in_q  <= in_rd;
      tie_q      <= out_rd[b_q];
      odeg_q     <= od_rd;
      ideg_q     <= id_rd;
    end
    if (ctrl.cap_b) begin
      set_q <= set_b & gats_pkg::NODE_MASK;
      acc_q <= '0;
    end
    if (ctrl.walk_step) begin
      kp_q  <= k_q;
      acc_q <= acc_nxt;
    end
    if (ctrl.walk_end) begin
      set_q <= acc_nxt & ~(RW'(1) << a_q) & gats_pkg::NODE_MASK;
    end
  end

  assign ok_o          = ok_q;
  assign tie_present_o = tie_q;
  assign out_degree_o  = odeg_q;
  assign in_degree_o   = ideg_q;
  assign node_set_o    = set_q;

  // One item in work at a time: never ready while a result is held.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("ready while a result is held");

  // A delivered result frees the block for the next request.
  a_free_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o)
    else $error("block not free after result transfer");

  // A plain query reaches out_valid_o through A_RD, B_RD and B_CAP.
  a_query_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == gats_pkg::REQ_TIE ||
     req_type_i == gats_pkg::REQ_OUT || req_type_i == gats_pkg::REQ_FWD))
    |-> ##4 out_valid_o)
    else $error("query latency wrong");

  // Only a refused tie change reports not ok, and it carries no set.
  a_refused_noset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (node_set_o == '0))
    else $error("refused request with nonzero set");

endmodule

>>> bench/graph_adjacency_tie_store_checker.sv
// Checker for the graph adjacency tie store: predicts every result and compares it.
// Depends on gats_pkg; watches the request, result and register ports.
`timescale 1ns / 1ps
module graph_adjacency_tie_store_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [3:0]  req_type_i,
  input  logic [5:0]  node_a_i,
  input  logic [5:0]  node_b_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        ok_i,
  input  logic        tie_present_i,
  input  logic [6:0]  out_degree_i,
  input  logic [6:0]  in_degree_i,
  input  logic [63:0] node_set_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        ok;
    logic        tie;
    logic [6:0]  odeg;
    logic [6:0]  ideg;
    logic [63:0] nset;
  } answer_t;

  logic [63:0] succ_row [64];
  logic [63:0] pred_row [64];
  logic [6:0]  succ_cnt [64];
  logic [6:0]  pred_cnt [64];
  logic        is_directed;
  logic        is_reflexive;
  answer_t     answers_due [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // Set one direction of a tie; degrees follow only a real bit change.
  function automatic void set_direction(input int a, input int b, input logic value);
    logic cur;
    cur = succ_row[a][b];
    if (a == b && !is_reflexive) return;
    if (value && !cur) begin
      succ_row[a][b] = 1'b1;
      pred_row[b][a] = 1'b1;
      succ_cnt[a]++;
      pred_cnt[b]++;
    end else if (!value && cur) begin
      succ_row[a][b] = 1'b0;
      pred_row[b][a] = 1'b0;
      succ_cnt[a]--;
      pred_cnt[b]--;
    end
  endfunction

  function automatic answer_t graph_answer(input logic [3:0] req, input int a, input int b);
    answer_t r;
    logic    value;
    r = '0;
    r.ok = 1'b1;
    if (req == gats_pkg::REQ_ADD || req == gats_pkg::REQ_REMOVE) begin
      value = (req == gats_pkg::REQ_ADD);
      if (a < gats_pkg::NODES && b < gats_pkg::NODES && succ_row[a][b] != value) begin
        if (a == b && !is_reflexive) begin
          r.ok = 1'b0;
        end else begin
          set_direction(a, b, value);
          if (!is_directed) set_direction(b, a, value);
        end
      end
    end else begin
      case (req)
        gats_pkg::REQ_OUT:   r.nset = succ_row[a];
        gats_pkg::REQ_IN:    r.nset = pred_row[a];
        gats_pkg::REQ_RECIP: r.nset = pred_row[a] & succ_row[a];
        gats_pkg::REQ_BACK:  r.nset = pred_row[a] & succ_row[b];
        gats_pkg::REQ_UP:    r.nset = succ_row[a] & succ_row[b];
        gats_pkg::REQ_DOWN:  r.nset = pred_row[a] & pred_row[b];
        gats_pkg::REQ_FWD:   r.nset = succ_row[a] & pred_row[b];
        gats_pkg::REQ_DIST2: begin
          for (int k = 0; k < 64; k++)
            if (succ_row[a][k]) r.nset |= succ_row[k];
          r.nset[a] = 1'b0;
        end
        default:   r.nset = '0;
      endcase
      r.nset &= gats_pkg::NODE_MASK;
    end
    r.tie  = succ_row[a][b];
    r.odeg = succ_cnt[a];
    r.ideg = pred_cnt[a];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 64; k++) begin
        succ_row[k] = '0;
        pred_row[k] = '0;
        succ_cnt[k] = '0;
        pred_cnt[k] = '0;
      end
      is_directed  = 1'b1;
      is_reflexive = 1'b0;
      answers_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == gats_pkg::CFG_DIRECTED) is_directed = cfg_data_i;
        else is_reflexive = cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        answers_due.push_back(graph_answer(req_type_i, node_a_i, node_b_i));
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          want = answers_due.pop_front();
          if (ok_i !== want.ok) report_mismatch("ok", ok_i, want.ok);
          if (tie_present_i !== want.tie) report_mismatch("tie_present", tie_present_i, want.tie);
          if (out_degree_i !== want.odeg) report_mismatch("out_degree", out_degree_i, want.odeg);
          if (in_degree_i !== want.ideg) report_mismatch("in_degree", in_degree_i, want.ideg);
          if (node_set_i !== want.nset) report_mismatch("node_set", node_set_i, want.nset);
        end
      end
      pending_o = answers_due.size();
    end
  end
endmodule

>>> bench/graph_adjacency_tie_store_core_tb.sv
// Testbench top for the graph adjacency tie store: clock, reset, stimulus, verdict.
// Depends on gats_pkg, graph_adjacency_tie_store_core and the checker module.
`timescale 1ns / 1ps
module graph_adjacency_tie_store_core_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i, cfg_idx_i, cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [3:0]  req_type_i;
  logic [5:0]  node_a_i, node_b_i;
  logic        out_valid_o, out_ready_i;
  logic        ok_o, tie_present_o;
  logic [6:0]  out_degree_o, in_degree_o;
  logic [63:0] node_set_o;
  int          fail_count, pending;
  logic        stim_done;

  graph_adjacency_tie_store_core dut (.*);

  graph_adjacency_tie_store_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .node_a_i, .node_b_i,
    .out_valid_i(out_valid_o), .out_ready_i, .ok_i(ok_o), .tie_present_i(tie_present_o),
    .out_degree_i(out_degree_o), .in_degree_i(in_degree_o), .node_set_i(node_set_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver side: toggle ready with random stalls.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = pick_gap();
      if (stall == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Drive one request and hold it until the transfer. Called at a falling
  // edge; ready is sampled there, as it only moves at rising edges.
  task automatic send_request(input logic [3:0] req, input logic [5:0] a, input logic [5:0] b);
    int   gap;
    logic rdy;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    node_a_i   <= a;
    node_b_i   <= b;
    rdy = in_ready_o;
    @(posedge clk_i);
    while (!rdy) begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Wait out every result, then write one register while idle.
  task automatic write_register(input gats_pkg::cfg_idx_e idx, input logic value);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly tie changes in the given node pool; a small one makes rows fill and degrees climb.
  task automatic random_request(input int pool);
    int r;
    logic [5:0] a, b;
    r = $urandom_range(0, 99);
    a = (pool == 64) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, pool - 1));
    b = (pool == 64) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, pool - 1));
    if ($urandom_range(0, 19) == 0) b = a;
    if (r < 40) send_request(gats_pkg::REQ_ADD, a, b);
    else if (r < 55) send_request(gats_pkg::REQ_REMOVE, a, b);
    else if (r < 95)
      send_request(4'($urandom_range(gats_pkg::REQ_TIE, gats_pkg::REQ_DIST2)), a, b);
    else send_request(4'($urandom_range(0, 15)), a, b);
  endtask

  initial begin
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = 1'b0;
    in_valid_i = 1'b0; req_type_i = '0; node_a_i = '0; node_b_i = '0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: refused self-tie, repeats, extremes, every named request code, two unused ones.
    send_request(gats_pkg::REQ_ADD, 6'd0, 6'd0);
    send_request(gats_pkg::REQ_ADD, 6'd0, 6'd63);
    send_request(gats_pkg::REQ_ADD, 6'd0, 6'd63);
    send_request(gats_pkg::REQ_ADD, 6'd63, 6'd0);
    send_request(gats_pkg::REQ_ADD, 6'd63, 6'd42);
    send_request(gats_pkg::REQ_ADD, 6'd42, 6'd21);
    send_request(gats_pkg::REQ_REMOVE, 6'd21, 6'd42);
    for (int q = gats_pkg::REQ_TIE; q <= gats_pkg::REQ_DIST2; q++)
      send_request(4'(q), 6'd0, 6'd63);
    send_request(gats_pkg::REQ_DIST2, 6'd63, 6'd0);
    send_request(4'd11, 6'd0, 6'd63);
    send_request(4'd15, 6'd63, 6'd0);
    send_request(gats_pkg::REQ_REMOVE, 6'd0, 6'd63);
    write_register(gats_pkg::CFG_REFLEXIVE, 1'b1);
    write_register(gats_pkg::CFG_DIRECTED, 1'b0);
    send_request(gats_pkg::REQ_ADD, 6'd5, 6'd5);
    send_request(gats_pkg::REQ_ADD, 6'd5, 6'd6);
    send_request(gats_pkg::REQ_REMOVE, 6'd6, 6'd5);
    send_request(gats_pkg::REQ_ADD, 6'd63, 6'd63);

    // Random phases across all four register settings.
    for (int phase = 0; phase < 8; phase++) begin
      write_register(gats_pkg::CFG_DIRECTED, phase[0]);
      write_register(gats_pkg::CFG_REFLEXIVE, phase[1]);
      for (int n = 0; n < 210; n++) random_request(phase[2] ? 64 : 12);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Hang guard: far above the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule

>>> filelist.f
sv/gats_pkg.sv
sv/gats_ram.sv
sv/gats_ctrl.sv
sv/graph_adjacency_tie_store_core.sv
bench/graph_adjacency_tie_store_checker.sv
bench/graph_adjacency_tie_store_core_tb.sv
